### hdl/sctab_pkg.sv
// shared constants and quarter-wave sample table for the sine/cosine unit
package sctab_pkg;

  localparam int unsigned AngleW    = 16;
  localparam int unsigned ValueW    = 16;
  localparam int unsigned FracW     = 7;
  localparam int unsigned TableLen  = 130;
  localparam int unsigned IdxW      = $clog2(TableLen);
  localparam int unsigned FoldW     = 15;
  localparam int unsigned DiffW     = ValueW + 1;
  localparam int unsigned ProdW     = DiffW + FracW;

  localparam logic [AngleW-1:0] QuarterTurn = 16'd16384;
  localparam logic [AngleW-1:0] HalfTurn    = 16'd32768;
  localparam logic [IdxW-1:0]   IdxMax      = IdxW'(TableLen - 2);

  typedef enum logic {
    CmdSine   = 1'b0,
    CmdCosine = 1'b1
  } cmd_e;

  typedef logic signed [ValueW-1:0] sample_t;

  localparam sample_t QuarterWave [TableLen] = '{
    16'sd0,     16'sd402,   16'sd804,   16'sd1206,  16'sd1607,  16'sd2009,
    16'sd2410,  16'sd2811,  16'sd3211,  16'sd3611,  16'sd4011,  16'sd4409,
    16'sd4807,  16'sd5205,  16'sd5601,  16'sd5997,  16'sd6392,  16'sd6786,
    16'sd7179,  16'sd7571,  16'sd7961,  16'sd8351,  16'sd8739,  16'sd9126,
    16'sd9511,  16'sd9895,  16'sd10278, 16'sd10659, 16'sd11038, 16'sd11416,
    16'sd11792, 16'sd12166, 16'sd12539, 16'sd12909, 16'sd13278, 16'sd13645,
    16'sd14009, 16'sd14372, 16'sd14732, 16'sd15090, 16'sd15446, 16'sd15799,
    16'sd16150, 16'sd16499, 16'sd16845, 16'sd17189, 16'sd17530, 16'sd17868,
    16'sd18204, 16'sd18537, 16'sd18867, 16'sd19194, 16'sd19519, 16'sd19840,
    16'sd20159, 16'sd20474, 16'sd20787, 16'sd21096, 16'sd21402, 16'sd21705,
    16'sd22004, 16'sd22301, 16'sd22594, 16'sd22883, 16'sd23169, 16'sd23452,
    16'sd23731, 16'sd24006, 16'sd24278, 16'sd24546, 16'sd24811, 16'sd25072,
    16'sd25329, 16'sd25582, 16'sd25831, 16'sd26077, 16'sd26318, 16'sd26556,
    16'sd26789, 16'sd27019, 16'sd27244, 16'sd27466, 16'sd27683, 16'sd27896,
    16'sd28105, 16'sd28309, 16'sd28510, 16'sd28706, 16'sd28897, 16'sd29085,
    16'sd29268, 16'sd29446, 16'sd29621, 16'sd29790, 16'sd29955, 16'sd30116,
    16'sd30272, 16'sd30424, 16'sd30571, 16'sd30713, 16'sd30851, 16'sd30984,
    16'sd31113, 16'sd31236, 16'sd31356, 16'sd31470, 16'sd31580, 16'sd31684,
    16'sd31785, 16'sd31880, 16'sd31970, 16'sd32056, 16'sd32137, 16'sd32213,
    16'sd32284, 16'sd32350, 16'sd32412, 16'sd32468, 16'sd32520, 16'sd32567,
    16'sd32609, 16'sd32646, 16'sd32678, 16'sd32705, 16'sd32727, 16'sd32744,
    16'sd32757, 16'sd32764, 16'sd32767, 16'sd32764
  };

endpackage

### hdl/sctab_rom.sv
// quarter-wave sample rom with two registered read ports
module sctab_rom (
  input  logic                          clk_i,
  input  logic [sctab_pkg::IdxW-1:0]    addr0_i,
  input  logic [sctab_pkg::IdxW-1:0]    addr1_i,
  output sctab_pkg::sample_t            data0_o,
  output sctab_pkg::sample_t            data1_o
);

  sctab_pkg::sample_t data0_q, data1_q;

  always_ff @(posedge clk_i) begin
    data0_q <= sctab_pkg::QuarterWave[addr0_i];
    data1_q <= sctab_pkg::QuarterWave[addr1_i];
  end

  assign data0_o = data0_q;
  assign data1_o = data1_q;

endmodule

### hdl/sine_cosine_table_interp.sv
// sine/cosine by quarter-wave table lookup with linear interpolation
// a beat taken passes the rom read, product and output registers in order, then shows on value_o with done_o
// throughput: one beat per cycle, busy never rises; the rom read, the
//   interpolation multiply and the final add/negate each take one pipeline stage
// reset clears only the stage valid bits; no result is lost or held since the receiver cannot stall
module sine_cosine_table_interp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command_i,
  input  logic [sctab_pkg::AngleW-1:0]         angle_i,
  output logic signed [sctab_pkg::ValueW-1:0]  value_o,
  output logic                                 done_o
);

  logic                                  accept;
  logic [sctab_pkg::AngleW-1:0]          ang;
  logic [sctab_pkg::AngleW-1:0]          folded_full;
  logic [sctab_pkg::FoldW-1:0]           folded;
  logic [sctab_pkg::IdxW-1:0]            idx;
  logic [sctab_pkg::IdxW-1:0]            idx_next;

  logic                                  v1_q, v2_q, v3_q;
  logic                                  neg1_q, neg2_q;
  logic [sctab_pkg::FracW-1:0]           frac1_q;
  sctab_pkg::sample_t                    s0, s1;
  sctab_pkg::sample_t                    s0_2_q;
  logic signed [sctab_pkg::DiffW-1:0]    diff;
  logic signed [sctab_pkg::ProdW-1:0]    prod_d, prod_q;
  logic signed [sctab_pkg::DiffW-1:0]    sum;
  logic signed [sctab_pkg::DiffW-1:0]    res;
  logic signed [sctab_pkg::ValueW-1:0]   value_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // cosine is sine a quarter turn ahead
  always_comb begin
    ang = angle_i;
    if (sctab_pkg::cmd_e'(command_i) == sctab_pkg::CmdCosine) begin
      ang = angle_i + sctab_pkg::QuarterTurn;
    end
    // mirror the second quarter of the half turn
    if (ang[14]) begin
      folded_full = sctab_pkg::HalfTurn - {1'b0, ang[14:0]};
    end else begin
      folded_full = {1'b0, ang[14:0]};
    end
    folded = folded_full[sctab_pkg::FoldW-1:0];
    idx    = folded[sctab_pkg::FoldW-1:sctab_pkg::FracW];
    if (idx > sctab_pkg::IdxMax) begin
      idx = sctab_pkg::IdxMax;
    end
    idx_next = idx + 1'b1;
  end

  sctab_rom u_rom (
    .clk_i   (clk_i),
    .addr0_i (idx),
    .addr1_i (idx_next),
    .data0_o (s0),
    .data1_o (s1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    frac1_q <= folded[sctab_pkg::FracW-1:0];
    neg1_q  <= ang[sctab_pkg::AngleW-1];
    s0_2_q  <= s0;
    neg2_q  <= neg1_q;
    prod_q  <= prod_d;
    value_q <= res[sctab_pkg::ValueW-1:0];
  end

  assign diff   = sctab_pkg::DiffW'(s1) - sctab_pkg::DiffW'(s0);
  assign prod_d = sctab_pkg::ProdW'($signed({1'b0, frac1_q}))
                * sctab_pkg::ProdW'(diff);

  // arithmetic shift floors, matching the interpolation rounding
  always_comb begin
    sum = sctab_pkg::DiffW'(s0_2_q)
        + sctab_pkg::DiffW'(prod_q >>> sctab_pkg::FracW);
    res = neg2_q ? -sum : sum;
  end

  assign value_o = value_q;
  assign done_o  = v3_q;

endmodule
